// ----- src/fmdp_pkg.sv -----
// Package for the FIX market data parser: widths, byte codes, result kinds,
// parser phases and the queue entry type. Depends on nothing.
package fmdp_pkg;

	localparam int FRAC_DIGITS = 5;
	localparam int PRICE_W = 48;
	localparam int QTY_W = 32;
	localparam int ACC_W = (PRICE_W > QTY_W) ? PRICE_W : QTY_W;
	localparam int MAC_W = ACC_W + 4;
	localparam int TAG_W = 10;
	localparam int FRAC_W = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] SOH_BYTE = 8'h01;
	localparam logic [7:0] EQ_BYTE = 8'h3D;
	localparam logic [7:0] POINT_BYTE = 8'h2E;
	localparam logic [7:0] TYPE_BID = 8'h30;
	localparam logic [7:0] TYPE_ASK = 8'h31;

	localparam logic [TAG_W-1:0] TAG_ENTRY_TYPE = TAG_W'(269);
	localparam logic [TAG_W-1:0] TAG_PRICE = TAG_W'(270);
	localparam logic [TAG_W-1:0] TAG_QUANTITY = TAG_W'(271);
	localparam logic [TAG_W-1:0] TAG_TRAILER = TAG_W'(10);
	localparam logic [TAG_W-1:0] TAG_MAX = '1;

	typedef enum logic [2:0] {
		KIND_BID,
		KIND_ASK,
		KIND_COMPLETE,
		KIND_ERROR,
		KIND_UNTERMINATED
	} kind_t;

	typedef enum logic [2:0] {
		PH_START,
		PH_TAG,
		PH_VALUE,
		PH_ERROR,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic upd_valid;
		logic upd_ask;
		logic [PRICE_W-1:0] raw_price;
		logic [FRAC_W-1:0] frac_count;
		logic [QTY_W-1:0] quantity;
		logic rpt_valid;
		kind_t rpt_kind;
	} event_t;

	function automatic logic [63:0] pow10(input logic [FRAC_W-1:0] n);
		logic [63:0] r;
		case (n)
			4'd0: r = 64'd1;
			4'd1: r = 64'd10;
			4'd2: r = 64'd100;
			4'd3: r = 64'd1000;
			4'd4: r = 64'd10000;
			4'd5: r = 64'd100000;
			4'd6: r = 64'd1000000;
			4'd7: r = 64'd10000000;
			4'd8: r = 64'd100000000;
			default: r = 64'd1;
		endcase
		return r;
	endfunction

	localparam int POW_W = $clog2(pow10(FRAC_W'(FRAC_DIGITS)) + 64'd1);

endpackage

// ----- src/fmdp_if.sv -----
// Valid/ready channel interfaces for message bytes and parser results.
// Depends on fmdp_pkg.
interface fmdp_in_if;
	import fmdp_pkg::*;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic message_end;
	modport source(output valid, data_byte, message_end, input ready);
	modport sink(input valid, data_byte, message_end, output ready);
endinterface

interface fmdp_out_if;
	import fmdp_pkg::*;
	logic valid;
	logic ready;
	kind_t kind;
	logic [PRICE_W-1:0] price;
	logic [QTY_W-1:0] quantity;
	logic last;
	modport source(output valid, kind, price, quantity, last, input ready);
	modport sink(input valid, kind, price, quantity, last, output ready);
endinterface

// ----- src/fmdp_front.sv -----
// Front end: accepts message bytes, runs the tag=value parser and builds one
// queue entry for every byte that causes results. Depends on fmdp_pkg.
module fmdp_front (
	input  logic clk,
	input  logic arst_n,
	fmdp_in_if.sink msg,
	input  logic q_full,
	output logic ev_push,
	output fmdp_pkg::event_t ev
);
	import fmdp_pkg::*;

	phase_t phase_q, phase_d;
	logic [TAG_W-1:0] tag_q, tag_d;
	logic [ACC_W-1:0] acc_q, acc_d;
	logic [FRAC_W-1:0] frac_q, frac_d;
	logic seen_q, seen_d;
	logic stopped_q, stopped_d;
	logic [7:0] first_q, first_d;
	logic [7:0] entry_q, entry_d;
	logic [PRICE_W-1:0] hprice_q, hprice_d;
	logic [FRAC_W-1:0] hfrac_q, hfrac_d;
	logic [QTY_W-1:0] hqty_q, hqty_d;
	logic hasp_q, hasp_d;
	logic hasq_q, hasq_d;

	logic take;
	logic [7:0] b;
	logic digit;
	logic [3:0] dval;
	logic [TAG_W+3:0] tag_mac;
	logic [TAG_W-1:0] tag_next;
	logic [MAC_W-1:0] num_max;
	logic [MAC_W-1:0] mac;
	logic [ACC_W-1:0] sat_val;
	logic commit;
	logic [PRICE_W-1:0] c_price;
	logic [FRAC_W-1:0] c_frac;
	logic [QTY_W-1:0] c_qty;

	assign msg.ready = !q_full;
	assign take = msg.valid && msg.ready;
	assign b = msg.data_byte;
	assign digit = b inside {[8'h30:8'h39]};
	assign dval = b[3:0];

	assign tag_mac = ({4'b0, tag_q} << 3) + ({4'b0, tag_q} << 1) + (TAG_W+4)'(dval);
	assign tag_next = (tag_mac > (TAG_W+4)'(TAG_MAX)) ? TAG_MAX : tag_mac[TAG_W-1:0];

	assign num_max = (tag_q == TAG_PRICE) ? MAC_W'({PRICE_W{1'b1}}) : MAC_W'({QTY_W{1'b1}});
	assign mac = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + MAC_W'(dval);
	assign sat_val = (mac > num_max) ? num_max[ACC_W-1:0] : mac[ACC_W-1:0];

	always_comb begin
		phase_d = phase_q;
		tag_d = tag_q;
		acc_d = acc_q;
		frac_d = frac_q;
		seen_d = seen_q;
		stopped_d = stopped_q;
		first_d = first_q;
		entry_d = entry_q;
		hprice_d = hprice_q;
		hfrac_d = hfrac_q;
		hqty_d = hqty_q;
		hasp_d = hasp_q;
		hasq_d = hasq_q;
		commit = 1'b0;
		c_price = hprice_q;
		c_frac = hfrac_q;
		c_qty = hqty_q;
		ev = '0;
		ev.rpt_kind = KIND_UNTERMINATED;

		case (phase_q)
			PH_START, PH_TAG: begin
				if (digit) begin
					tag_d = tag_next;
					phase_d = PH_TAG;
				end else if (b == EQ_BYTE && phase_q == PH_TAG) begin
					acc_d = '0;
					frac_d = '0;
					seen_d = 1'b0;
					stopped_d = 1'b0;
					first_d = '0;
					phase_d = PH_VALUE;
				end else begin
					phase_d = PH_ERROR;
				end
			end
			PH_VALUE: begin
				if (b == SOH_BYTE) begin
					case (tag_q)
						TAG_ENTRY_TYPE: begin
							entry_d = first_q;
							hasp_d = 1'b0;
							hasq_d = 1'b0;
						end
						TAG_PRICE: begin
							hprice_d = acc_q[PRICE_W-1:0];
							hfrac_d = frac_q;
							hasp_d = 1'b1;
							c_price = acc_q[PRICE_W-1:0];
							c_frac = frac_q;
							commit = hasq_q;
						end
						TAG_QUANTITY: begin
							hqty_d = acc_q[QTY_W-1:0];
							hasq_d = 1'b1;
							c_qty = acc_q[QTY_W-1:0];
							commit = hasp_q;
						end
						default: begin
						end
					endcase
					if (commit) begin
						ev.upd_valid = (entry_q == TYPE_BID) || (entry_q == TYPE_ASK);
						ev.upd_ask = (entry_q == TYPE_ASK);
						ev.raw_price = c_price;
						ev.frac_count = c_frac;
						ev.quantity = c_qty;
						entry_d = '0;
						hprice_d = '0;
						hfrac_d = '0;
						hqty_d = '0;
						hasp_d = 1'b0;
						hasq_d = 1'b0;
					end
					phase_d = (tag_q == TAG_TRAILER) ? PH_DONE : PH_START;
					tag_d = '0;
					acc_d = '0;
					frac_d = '0;
					seen_d = 1'b0;
					stopped_d = 1'b0;
					first_d = '0;
				end else begin
					case (tag_q)
						TAG_ENTRY_TYPE: begin
							if (acc_q == '0) begin
								first_d = b;
								acc_d = ACC_W'(1);
							end
						end
						TAG_PRICE: begin
							if (!stopped_q) begin
								if (digit) begin
									if (!seen_q) begin
										acc_d = sat_val;
									end else if (frac_q < FRAC_W'(FRAC_DIGITS)) begin
										acc_d = sat_val;
										frac_d = frac_q + FRAC_W'(1);
									end
								end else if (b == POINT_BYTE && !seen_q) begin
									seen_d = 1'b1;
								end else begin
									stopped_d = 1'b1;
								end
							end
						end
						TAG_QUANTITY: begin
							if (!stopped_q) begin
								if (digit) begin
									acc_d = sat_val;
								end else begin
									stopped_d = 1'b1;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			PH_DONE: begin
			end
			default: begin
				phase_d = PH_ERROR;
			end
		endcase

		if (msg.message_end) begin
			ev.rpt_valid = 1'b1;
			if (phase_d == PH_DONE) begin
				ev.rpt_kind = KIND_COMPLETE;
			end else if (phase_d == PH_ERROR) begin
				ev.rpt_kind = KIND_ERROR;
			end else begin
				ev.rpt_kind = KIND_UNTERMINATED;
			end
			phase_d = PH_START;
			tag_d = '0;
			acc_d = '0;
			frac_d = '0;
			seen_d = 1'b0;
			stopped_d = 1'b0;
			first_d = '0;
			entry_d = '0;
			hprice_d = '0;
			hfrac_d = '0;
			hqty_d = '0;
			hasp_d = 1'b0;
			hasq_d = 1'b0;
		end
	end

	assign ev_push = take && (ev.upd_valid || ev.rpt_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
		end else if (take) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
			acc_q <= '0;
			frac_q <= '0;
			seen_q <= 1'b0;
			stopped_q <= 1'b0;
			first_q <= '0;
			entry_q <= '0;
			hprice_q <= '0;
			hfrac_q <= '0;
			hqty_q <= '0;
			hasp_q <= 1'b0;
			hasq_q <= 1'b0;
		end else if (take) begin
			tag_q <= tag_d;
			acc_q <= acc_d;
			frac_q <= frac_d;
			seen_q <= seen_d;
			stopped_q <= stopped_d;
			first_q <= first_d;
			entry_q <= entry_d;
			hprice_q <= hprice_d;
			hfrac_q <= hfrac_d;
			hqty_q <= hqty_d;
			hasp_q <= hasp_d;
			hasq_q <= hasq_d;
		end
	end

endmodule

// ----- src/fmdp_queue.sv -----
// Short queue of parser events between the front end and the result stage.
// Depends on fmdp_pkg.
module fmdp_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  fmdp_pkg::event_t push_ev,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output fmdp_pkg::event_t head_ev
);
	import fmdp_pkg::*;

	event_t entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_ev = entries_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + (QPTR_W+1)'(1);
				2'b01: count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- src/fmdp_back.sv -----
// Result stage: takes queued events, scales held prices to fixed point with
// saturation and issues one result per transfer. Depends on fmdp_pkg.
module fmdp_back (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  fmdp_pkg::event_t head_ev,
	output logic pop,
	fmdp_out_if.source result
);
	import fmdp_pkg::*;

	logic valid_q;
	kind_t kind_q;
	logic [PRICE_W-1:0] price_q;
	logic [QTY_W-1:0] qty_q;
	logic last_q;
	logic half_q;

	logic load;
	logic emit_upd;
	logic [FRAC_W-1:0] shift;
	logic [POW_W-1:0] scale;
	logic [PRICE_W+POW_W-1:0] product;
	logic [PRICE_W-1:0] scaled;

	assign shift = FRAC_W'(FRAC_DIGITS) - head_ev.frac_count;
	assign scale = POW_W'(pow10(shift));
	assign product = (PRICE_W+POW_W)'(head_ev.raw_price) * (PRICE_W+POW_W)'(scale);
	assign scaled = (|product[PRICE_W+POW_W-1:PRICE_W]) ? '1 : product[PRICE_W-1:0];

	assign load = head_valid && (!valid_q || result.ready);
	assign emit_upd = head_ev.upd_valid && !half_q;
	assign pop = load && !(emit_upd && head_ev.rpt_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				half_q <= !pop;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (emit_upd) begin
				kind_q <= head_ev.upd_ask ? KIND_ASK : KIND_BID;
				price_q <= scaled;
				qty_q <= head_ev.quantity;
				last_q <= !head_ev.rpt_valid;
			end else begin
				kind_q <= head_ev.rpt_kind;
				price_q <= '0;
				qty_q <= '0;
				last_q <= 1'b1;
			end
		end
	end

	assign result.valid = valid_q;
	assign result.kind = kind_q;
	assign result.price = price_q;
	assign result.quantity = qty_q;
	assign result.last = last_q;

endmodule

// ----- src/fix_market_data_parser_top.sv -----
// Top level of the FIX market data parser: front end, event queue and
// result stage. Depends on fmdp_pkg, fmdp_if, fmdp_front, fmdp_queue, fmdp_back.
//
// Channel  Role    Payload
// msg      sink    data_byte[7:0], message_end
// result   source  kind[2:0], price[47:0], quantity[31:0], last
//
// One byte is accepted per cycle while the four-entry event queue has room.
// A result is registered first in the event queue and then, through the price
// scaling multiplier, in the output register.
// A byte that both completes an update and ends a message yields two results,
// issued one after the other from one queue entry.
// Reset returns the parser to the start of a message and empties the queue.
module fix_market_data_parser_top (
	input  logic clk,
	input  logic arst_n,
	fmdp_in_if.sink msg,
	fmdp_out_if.source result
);
	import fmdp_pkg::*;

	event_t ev;
	event_t head_ev;
	logic ev_push;
	logic q_full;
	logic head_valid;
	logic pop;

	fmdp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.msg(msg),
		.q_full(q_full),
		.ev_push(ev_push),
		.ev(ev)
	);

	fmdp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(ev_push),
		.push_ev(ev),
		.full(q_full),
		.pop(pop),
		.head_valid(head_valid),
		.head_ev(head_ev)
	);

	fmdp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_ev(head_ev),
		.pop(pop),
		.result(result)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		ev_push |-> !q_full)
		else $error("event pushed into a full queue");

	a_end_makes_report: assert property (@(posedge clk) disable iff (!arst_n)
		(msg.valid && msg.ready && msg.message_end) |-> (ev_push && ev.rpt_valid))
		else $error("message end without a report event");

	a_not_last_is_update: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.last) |-> (result.kind == KIND_BID || result.kind == KIND_ASK))
		else $error("non-final result is not an update");

	a_report_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.kind != KIND_BID && result.kind != KIND_ASK)
		|-> (result.price == '0 && result.quantity == '0 && result.last))
		else $error("report result carries payload or is not final");

endmodule
